// ----- hw/rtl/lzwc_pkg.sv -----
// lzwc_pkg: shared types and constants for the lzw compressor
// no dependencies
package lzwc_pkg;

   localparam int BYTE_BITS      = 8;
   localparam int CODE_WORD_BITS = 16;
   localparam int HASH_KEY_BITS  = 24;
   localparam int HASH_BITS      = 32;
   localparam logic [HASH_BITS-1:0] HASH_MULT = 32'h9E37_79B1;
   localparam logic [BYTE_BITS-1:0] SIGN_FLIP = 8'h80;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_START,
      ST_HASH,
      ST_READ,
      ST_CHECK,
      ST_EMIT,
      ST_FINAL
   } seq_state_type;

endpackage

// ----- hw/rtl/lzwc_if.sv -----
// lzwc_req_if / lzwc_rsp_if: valid/ready channels for bytes and codes
// depends on lzwc_pkg
interface lzwc_req_if;
   import lzwc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] data_byte;
   logic                 end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface lzwc_rsp_if;
   import lzwc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CODE_WORD_BITS-1:0] code_word;
   logic                      final_code;

   modport source (output valid, output code_word, output final_code, input ready);
   modport sink   (input valid, input code_word, input final_code, output ready);
endinterface

// ----- hw/rtl/lzwc_hash.sv -----
// lzwc_hash: registered multiplicative hash giving the home slot of a key
// depends on lzwc_pkg
module lzwc_hash #(
   parameter int CODE_BITS = 16
) (
   input  logic                   clock,
   input  logic [CODE_BITS+7:0]   key,
   output logic [CODE_BITS-1:0]   slot
);
   import lzwc_pkg::*;

   logic [HASH_BITS-1:0] product_in;
   logic [HASH_BITS-1:0] product_ff;

   // key times golden-ratio constant, low word kept
   always_comb begin
      product_in = {{(HASH_BITS-CODE_BITS-8){1'b0}}, key} * HASH_MULT;
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   // top bits select the slot
   assign slot = product_ff[HASH_BITS-1 -: CODE_BITS];

endmodule

// ----- hw/rtl/lzwc_table.sv -----
// lzwc_table: single-port-write, registered-read dictionary memory
// no package dependencies
module lzwc_table #(
   parameter int ADDR_BITS = 16,
   parameter int DATA_BITS = 41
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hw/rtl/lzw_compressor_fixed_code_top.sv -----
// lzw_compressor_fixed_code_top: lzw compressor with fixed-width codes
// depends on lzwc_pkg, lzwc_if, lzwc_hash, lzwc_table
//
// One byte is taken per transfer on req_chan and up to two codes leave on
// rsp_chan. A byte that starts a message passes through ST_START only;
// otherwise it goes through ST_START, ST_HASH, then ST_READ and ST_CHECK
// for each hash probe, and ST_EMIT on a miss. Every probe goes through the
// single read port of the dictionary memory. A last byte adds ST_FINAL for
// its final code, and a code that waits on rsp_chan holds the block until
// it leaves. After reset, when the dictionary is full, and after a message
// that added entries, a clearing pass sweeps all 2^CODE_BITS slots of the
// memory one slot per cycle, and no byte is taken then.
module lzw_compressor_fixed_code_top #(
   parameter int CODE_BITS = 16
) (
   input logic clock,
   input logic reset,
   lzwc_req_if.sink   req_chan,
   lzwc_rsp_if.source rsp_chan
);
   import lzwc_pkg::*;

   localparam int KEY_BITS   = CODE_BITS + BYTE_BITS;
   localparam int ENTRY_BITS = 1 + KEY_BITS + CODE_BITS;
   localparam logic [CODE_BITS-1:0] DMS        = {CODE_BITS{1'b1}};
   localparam logic [CODE_BITS-1:0] FIRST_FREE = CODE_BITS'(256);
   localparam logic [CODE_BITS-1:0] LAST_SLOT  = {CODE_BITS{1'b1}};

   seq_state_type state_ff, state_in;
   logic [CODE_BITS-1:0] prefix_ff, prefix_in;
   logic                 present_ff, present_in;
   logic [CODE_BITS-1:0] nfc_ff, nfc_in;
   logic [BYTE_BITS-1:0] byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic [CODE_BITS-1:0] count_ff, count_in;
   logic [CODE_BITS-1:0] slot_ff, slot_in;
   logic                 first_ff, first_in;
   logic                 ret_start_ff, ret_start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CODE_BITS-1:0] rsp_code_ff, rsp_code_in;
   logic                 rsp_final_ff, rsp_final_in;

   logic [KEY_BITS-1:0]   key;
   logic [CODE_BITS-1:0]  hash_slot;
   logic                  wr_en;
   logic [CODE_BITS-1:0]  wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic [CODE_BITS-1:0]  rd_addr;
   logic [ENTRY_BITS-1:0] rd_data;
   logic                  rd_valid;
   logic [KEY_BITS-1:0]   rd_key;
   logic [CODE_BITS-1:0]  rd_value;
   logic                  out_free;
   logic [CODE_BITS-1:0]  byte_code;

   assign key       = {prefix_ff, byte_ff};
   assign byte_code = {{(CODE_BITS-BYTE_BITS){1'b0}}, byte_ff ^ SIGN_FLIP};
   assign rd_valid  = rd_data[ENTRY_BITS-1];
   assign rd_key    = rd_data[ENTRY_BITS-2 -: KEY_BITS];
   assign rd_value  = rd_data[CODE_BITS-1:0];
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   lzwc_hash #(.CODE_BITS(CODE_BITS)) u_hash (
      .clock (clock),
      .key   (key),
      .slot  (hash_slot)
   );

   lzwc_table #(.ADDR_BITS(CODE_BITS), .DATA_BITS(ENTRY_BITS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         present_ff   <= 1'b0;
         nfc_ff       <= FIRST_FREE;
         count_ff     <= '0;
         ret_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prefix_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         nfc_ff       <= nfc_in;
         count_ff     <= count_in;
         ret_start_ff <= ret_start_in;
         rsp_valid_ff <= rsp_valid_in;
         prefix_ff    <= prefix_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      slot_ff      <= slot_in;
      first_ff     <= first_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_final_ff <= rsp_final_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      prefix_in    = prefix_ff;
      present_in   = present_ff;
      nfc_in       = nfc_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      first_in     = first_ff;
      ret_start_in = ret_start_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_code_in  = rsp_code_ff;
      rsp_final_in = rsp_final_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff;
      wr_data      = '0;
      rd_addr      = slot_ff;
      req_chan.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               byte_in = req_chan.data_byte;
               last_in = req_chan.end_of_message;
               if (nfc_ff == DMS) begin
                  nfc_in       = FIRST_FREE;
                  count_in     = '0;
                  ret_start_in = 1'b1;
                  state_in     = ST_CLEAR;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_CLEAR: begin
            // sweep one slot per cycle, valid bit cleared
            wr_en    = 1'b1;
            wr_addr  = count_ff;
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_SLOT) begin
               state_in = ret_start_ff ? ST_START : ST_IDLE;
            end
         end
         ST_START: begin
            if (!present_ff) begin
               prefix_in  = byte_code;
               present_in = 1'b1;
               state_in   = last_ff ? ST_FINAL : ST_IDLE;
            end else begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            count_in = '0;
            first_in = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            rd_addr  = first_ff ? hash_slot : slot_ff;
            slot_in  = rd_addr;
            first_in = 1'b0;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!rd_valid) begin
               // miss with a free slot: insert
               wr_en    = 1'b1;
               wr_addr  = slot_ff;
               wr_data  = {1'b1, key, nfc_ff};
               nfc_in   = nfc_ff + 1'b1;
               state_in = ST_EMIT;
            end else if (rd_key == key) begin
               prefix_in = rd_value;
               state_in  = last_ff ? ST_FINAL : ST_IDLE;
            end else if (count_ff == LAST_SLOT) begin
               // every slot probed: miss without insert
               nfc_in   = nfc_ff + 1'b1;
               state_in = ST_EMIT;
            end else begin
               count_in = count_ff + 1'b1;
               slot_in  = slot_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = prefix_ff;
               rsp_final_in = 1'b0;
               prefix_in    = byte_code;
               state_in     = last_ff ? ST_FINAL : ST_IDLE;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = prefix_ff;
               rsp_final_in = 1'b1;
               present_in   = 1'b0;
               prefix_in    = '0;
               nfc_in       = FIRST_FREE;
               if (nfc_ff != FIRST_FREE) begin
                  count_in     = '0;
                  ret_start_in = 1'b0;
                  state_in     = ST_CLEAR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result channel
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.code_word  = {{(CODE_WORD_BITS-CODE_BITS){1'b0}}, rsp_code_ff};
   assign rsp_chan.final_code = rsp_final_ff;

   // a table insert only lands on a free slot
   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && wr_en) |-> !rd_valid)
      else $error("insert over a valid slot");

   // a result is only loaded by the emit states
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT || $past(state_ff) == ST_FINAL))
      else $error("result loaded outside emit states");

   // idle with an empty dictionary or with a pending string
   a_idle_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (nfc_ff == FIRST_FREE || present_ff))
      else $error("dictionary grown with no pending string");

   // a final code leaves the pending string empty
   a_final_reset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL && out_free) |=> !present_ff)
      else $error("pending string kept after final code");

endmodule

// ----- verif/lzwc_checker.sv -----
// lzwc_checker: watches the byte and code channels, predicts the lzw codes
// and compares every code transfer with the oldest expected one
// depends on lzwc_pkg and the channel interfaces in lzwc_if
module lzwc_checker #(
   parameter int CODE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   lzwc_req_if        req_chan,
   lzwc_rsp_if        rsp_chan,
   output int         fail_count,
   output int         pending_codes
);
   timeunit 1ns;
   timeprecision 1ps;
   import lzwc_pkg::*;

   localparam int unsigned SLOTS      = 1 << CODE_BITS;
   localparam int unsigned LAST_CODE  = SLOTS - 1;
   localparam int unsigned FIRST_FREE = 256;

   typedef struct packed {
      logic [CODE_WORD_BITS-1:0] code_word;
      logic                      final_code;
   } code_item_t;

   code_item_t expected_codes[$];

   // dictionary copy and pending string
   logic [HASH_KEY_BITS-1:0]  dict_key   [SLOTS];
   logic [CODE_WORD_BITS-1:0] dict_code  [SLOTS];
   bit                        dict_used  [SLOTS];
   logic [CODE_WORD_BITS-1:0] pending_prefix;
   bit                        have_prefix;
   int unsigned               free_code;
   int                        mismatch_count;

   function automatic void clear_dictionary();
      foreach (dict_used[i]) dict_used[i] = 0;
      free_code = FIRST_FREE;
   endfunction

   function automatic void restart_compressor();
      clear_dictionary();
      pending_prefix = '0;
      have_prefix    = 0;
   endfunction

   // one byte in, zero to two codes queued
   function automatic void compress_byte(logic [BYTE_BITS-1:0] b, logic last);
      logic [HASH_KEY_BITS-1:0] k;
      logic [HASH_BITS-1:0]     h;
      int unsigned              s;
      int unsigned              free_slot;
      bit                       hit;
      code_item_t               c;
      hit       = 0;
      free_slot = SLOTS;
      if (free_code == LAST_CODE) clear_dictionary();
      if (!have_prefix) begin
         pending_prefix = {8'h00, b ^ SIGN_FLIP};
         have_prefix    = 1;
      end else begin
         k = {pending_prefix, b};
         h = {8'h00, k} * HASH_MULT;
         s = (h >> (32 - CODE_BITS)) & (SLOTS - 1);
         // linear probe until a hit or an empty slot
         for (int unsigned n = 0; n < SLOTS; n++) begin
            if (!dict_used[s]) begin
               free_slot = s;
               break;
            end
            if (dict_key[s] == k) begin
               hit = 1;
               pending_prefix = dict_code[s];
               break;
            end
            s = (s + 1) & (SLOTS - 1);
         end
         if (!hit) begin
            if (free_slot < SLOTS) begin
               dict_key[free_slot]  = k;
               dict_code[free_slot] = free_code[CODE_WORD_BITS-1:0];
               dict_used[free_slot] = 1;
            end
            free_code++;
            c.code_word  = pending_prefix;
            c.final_code = 1'b0;
            expected_codes = {expected_codes, c};
            pending_prefix = {8'h00, b ^ SIGN_FLIP};
         end
      end
      if (last) begin
         c.code_word  = pending_prefix;
         c.final_code = 1'b1;
         expected_codes = {expected_codes, c};
         restart_compressor();
      end
   endfunction

   // byte transfers feed the predictor, code transfers are compared
   always @(posedge clock) begin
      code_item_t want;
      if (reset) begin
         restart_compressor();
         fail_count     = 0;
         mismatch_count = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            compress_byte(req_chan.data_byte, req_chan.end_of_message);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_codes.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected code %h final %b", $realtime,
                           rsp_chan.code_word, rsp_chan.final_code);
            end else begin
               want = expected_codes.pop_front();
               if (want.code_word !== rsp_chan.code_word ||
                   want.final_code !== rsp_chan.final_code) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: code mismatch: expected %h final %b, got %h final %b",
                              $realtime, want.code_word, want.final_code,
                              rsp_chan.code_word, rsp_chan.final_code);
               end
            end
         end
      end
      pending_codes = expected_codes.size();
   end

endmodule

// ----- verif/tb.sv -----
// tb: stimulus and verdict for the lzw compressor
// depends on lzwc_pkg, lzwc_if, lzw_compressor_fixed_code_top and lzwc_checker
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lzwc_pkg::*;

   // small codes keep the clearing pass short and let the dictionary fill
   localparam int CODE_BITS   = 9;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_codes;
   int   cycle_count;
   int   burst_left;
   bit   hold_go;
   bit   hold_done;
   int   hold_left;
   int   stall_phase;
   int   stall_mode;

   lzwc_req_if req_chan ();
   lzwc_rsp_if rsp_chan ();

   lzw_compressor_fixed_code_top #(.CODE_BITS(CODE_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   lzwc_checker #(.CODE_BITS(CODE_BITS)) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending_codes (pending_codes)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // code receiver: changing stall pattern plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_phase    <= 0;
         stall_mode     <= 0;
         hold_left      <= 0;
         hold_done      <= 0;
      end else if (hold_go && !hold_done) begin
         hold_done      <= 1;
         hold_left      <= 3000;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= 1'($urandom_range(0, 1));
            2: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // one byte transfer, with bursts and random gaps between them
   task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic last);
      bit took;
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_chan.valid          <= 1'b1;
      req_chan.data_byte      <= b;
      req_chan.end_of_message <= last;
      do begin
         @(negedge clock);
         took = req_chan.ready;
         @(posedge clock);
      end while (!took);
      burst_left--;
   endtask

   // message of random bytes; narrow alphabets make dictionary hits
   task automatic send_message(input int len, input int alphabet);
      logic [BYTE_BITS-1:0] b;
      for (int i = 0; i < len; i++) begin
         if (alphabet >= 256) b = 8'($urandom_range(0, 255));
         else b = 8'h41 + 8'($urandom_range(0, alphabet - 1));
         send_byte(b, i == len - 1);
      end
   endtask

   initial begin
      burst_left              = 0;
      hold_go                 = 0;
      reset                   = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.data_byte      = '0;
      req_chan.end_of_message = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // single-byte messages at the byte extremes
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h7F, 1'b1);
      // repeated pattern: misses then dictionary hits
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h41, 1'b1);
      // last byte misses after the byte before it hit an existing string
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b1);
      // run of equal bytes at the top of the range
      for (int i = 0; i < 8; i++) send_byte(8'hFF, i == 7);

      // receiver holds off while a long message fills the dictionary
      hold_go = 1;
      send_message(320, 256);

      // random messages, mostly short with narrow alphabets
      for (int m = 0; m < 20; m++) begin
         if ($urandom_range(0, 3) == 0) send_message($urandom_range(1, 12), 256);
         else send_message($urandom_range(1, 20), $urandom_range(1, 6));
      end
      req_chan.valid <= 1'b0;

      // drain, then let the block settle
      @(posedge clock);
      while (pending_codes != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
